FILE: sv/sfhd_pkg.sv
// Shared types, constants and Fire code helpers for the super frame header decoder.
// Used by the front parser, the job queue, the back sequencer and the checker.
`default_nettype none
package sfhd_pkg;

  localparam int HeaderBytes = 11;
  localparam int MaxUnits    = 6;
  localparam int NumStarts   = MaxUnits - 1;
  localparam int QueueDepth  = 2;

  localparam logic [3:0]  POS_LAST   = 4'(HeaderBytes - 1);
  localparam logic [15:0] FIRE_POLY  = 16'h782f;
  localparam logic [12:0] MAX_AU_LEN = 13'd962;

  // record status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_PS    = 3'd1;
  localparam logic [2:0] ST_ORDER = 3'd2;
  localparam logic [2:0] ST_LEN   = 3'd3;
  localparam logic [2:0] ST_FIRE  = 3'd4;

  // flags: [3] dac 48k, [2] sbr, [1] stereo, [0] ps
  typedef struct packed {
    logic [3:0]                  flags;
    logic [NumStarts-1:0][11:0]  starts;
    logic [15:0]                 fire;
    logic [15:0]                 lead;
  } job_t;

  typedef struct packed {
    logic [2:0]  au_index;
    logic [11:0] au_offset;
    logic [9:0]  au_length;
    logic [2:0]  num_aus;
    logic [3:0]  flags;
    logic [2:0]  status;
    logic        last;
  } rec_t;

  // one entry of the Fire code table, indexed by a byte
  function automatic logic [15:0] fire_table(input logic [7:0] idx);
    logic [15:0] v;
    v = {idx, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (v[15]) v = {v[14:0], 1'b0} ^ FIRE_POLY;
      else       v = {v[14:0], 1'b0};
    end
    return v;
  endfunction

  // shift one byte into the Fire code register
  function automatic logic [15:0] fire_step(input logic [15:0] st, input logic [7:0] b);
    logic [15:0] t;
    t = fire_table(st[15:8]);
    return {t[15:8] ^ st[7:0], t[7:0] ^ b};
  endfunction

  function automatic logic [2:0] num_units(input logic [3:0] flags);
    logic [2:0] n;
    if (flags[2]) n = flags[3] ? 3'd3 : 3'd2;
    else          n = flags[3] ? 3'd6 : 3'd4;
    return n;
  endfunction

  function automatic logic [11:0] first_start(input logic [3:0] flags);
    logic [11:0] s;
    if (flags[2]) s = flags[3] ? 12'd6 : 12'd5;
    else          s = flags[3] ? 12'd11 : 12'd8;
    return s;
  endfunction

endpackage
`default_nettype wire

FILE: sv/sfhd_front.sv
// Front parser: accepts super frame bytes, collects the header and the Fire code,
// and pushes one job per completed header. Depends on sfhd_pkg.
`default_nettype none
module sfhd_front import sfhd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       frame_start,
  input  wire logic [7:0] byte_value,
  input  wire logic       q_full,
  output logic            push,
  output job_t            push_job
);

  logic                       active;
  logic [3:0]                 pos;
  logic [15:0]                lead;
  logic [15:0]                fire;
  logic [3:0]                 flags;
  logic [NumStarts-1:0][11:0] starts;

  logic       accept;
  logic       take;
  logic [3:0] epos;
  logic       finish;
  logic [15:0] fire_adv;

  // hold off only when a header would complete into a full queue
  assign in_ready = !(active && (pos == POS_LAST) && q_full);
  assign accept   = in_valid && in_ready;
  assign take     = accept && (frame_start || active);
  assign epos     = frame_start ? 4'd0 : pos;
  assign finish   = take && (epos >= POS_LAST);
  assign fire_adv = fire_step(fire, byte_value);

  // assemble the job from the stored header and the closing byte
  always_comb begin
    push_job.flags  = flags;
    push_job.starts = starts;
    push_job.starts[NumStarts-1][3:0] = byte_value[7:4];
    push_job.fire   = fire_adv;
    push_job.lead   = lead;
  end
  assign push = finish;

  // advance the byte position and collect the flags and the Fire code
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pos    <= 4'd0;
      fire   <= 16'd0;
      flags  <= 4'd0;
    end else if (take) begin
      if (finish) begin
        active <= 1'b0;
        pos    <= 4'd0;
      end else begin
        active <= 1'b1;
        pos    <= epos + 4'd1;
      end
      unique case (epos)
        4'd0, 4'd1: ;
        4'd2: begin
          flags <= byte_value[6:3];
          fire  <= {byte_value, 8'h00};
        end
        4'd3:    fire <= {fire[15:8], byte_value};
        default: fire <= fire_adv;
      endcase
    end
  end

  // capture the leading bytes and the packed start fields
  always_ff @(posedge clk) begin
    if (take) begin
      unique case (epos)
        4'd0: lead[15:8] <= byte_value;
        4'd1: lead[7:0]  <= byte_value;
        4'd3: starts[0][11:4] <= byte_value;
        4'd4: begin
          starts[0][3:0]  <= byte_value[7:4];
          starts[1][11:8] <= byte_value[3:0];
        end
        4'd5: starts[1][7:0]  <= byte_value;
        4'd6: starts[2][11:4] <= byte_value;
        4'd7: begin
          starts[2][3:0]  <= byte_value[7:4];
          starts[3][11:8] <= byte_value[3:0];
        end
        4'd8:  starts[3][7:0]  <= byte_value;
        4'd9:  starts[4][11:4] <= byte_value;
        4'd10: starts[4][3:0]  <= byte_value[7:4];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sv/sfhd_queue.sv
// Two-entry job queue between the front parser and the back sequencer.
// Depends on sfhd_pkg for job_t and QueueDepth.
`default_nettype none
module sfhd_queue import sfhd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  job_t      push_job,
  output logic      full,
  input  wire logic pop,
  output logic      pop_valid,
  output job_t      pop_job
);

  localparam int PtrW = $clog2(QueueDepth);

  job_t                entries [QueueDepth];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [PtrW:0]       count;

  assign full      = (count == (PtrW + 1)'(QueueDepth));
  assign pop_valid = (count != '0);
  assign pop_job   = entries[rd_ptr];

  // store a pushed job
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PtrW'(1);
      if (pop)  rd_ptr <= rd_ptr + PtrW'(1);
      if (push && !pop)      count <= count + (PtrW + 1)'(1);
      else if (pop && !push) count <= count - (PtrW + 1)'(1);
    end
  end

endmodule
`default_nettype wire

FILE: sv/sfhd_back.sv
// Back sequencer: finishes the Fire code, checks each access unit in turn and
// drives the record output register. Depends on sfhd_pkg.
`default_nettype none
module sfhd_back import sfhd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [12:0] frame_size,
  input  wire logic        q_valid,
  input  job_t             q_job,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output rec_t             out_rec
);

  typedef enum logic [5:0] {
    B_IDLE    = 6'b000001,
    B_FIRE_HI = 6'b000010,
    B_FIRE_LO = 6'b000100,
    B_CHECK   = 6'b001000,
    B_ERR     = 6'b010000,
    B_EMIT    = 6'b100000
  } bstate_t;

  bstate_t     state;
  job_t        job;
  logic [15:0] fire;
  logic [2:0]  idx;
  logic [2:0]  err_status;
  logic [2:0]  err_index;
  logic [11:0] err_start;
  logic [2:0]  err_num;

  logic [2:0]  n;
  logic        is_last;
  logic [11:0] cur;
  logic [11:0] stored_next;
  logic [12:0] nxt;
  logic [12:0] diff;
  logic        order_bad;
  logic        len_bad;
  logic        ps_bad;
  logic        load;
  logic        emit;

  assign n       = num_units(job.flags);
  assign is_last = (idx == n - 3'd1);
  assign ps_bad  = job.flags[0] && (!job.flags[2] || job.flags[1]);
  assign load    = !out_valid || out_ready;
  assign emit    = load && ((state == B_ERR) || (state == B_EMIT));
  assign pop     = (state == B_IDLE) && q_valid;

  // select the start of this unit and of the next one
  always_comb begin
    unique case (idx)
      3'd0:    cur = first_start(job.flags);
      3'd1:    cur = job.starts[0];
      3'd2:    cur = job.starts[1];
      3'd3:    cur = job.starts[2];
      3'd4:    cur = job.starts[3];
      default: cur = job.starts[4];
    endcase
    unique case (idx)
      3'd0:    stored_next = job.starts[0];
      3'd1:    stored_next = job.starts[1];
      3'd2:    stored_next = job.starts[2];
      3'd3:    stored_next = job.starts[3];
      default: stored_next = job.starts[4];
    endcase
  end

  assign nxt       = is_last ? frame_size : {1'b0, stored_next};
  assign order_bad = nxt < {1'b0, cur};
  assign diff      = nxt - {1'b0, cur};
  assign len_bad   = diff > MAX_AU_LEN;

  // sequence the checks and the records
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      idx       <= 3'd0;
    end else begin
      // raise valid on a new word, drop it once taken
      if (emit)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (q_valid) begin
            job   <= q_job;
            fire  <= q_job.fire;
            state <= B_FIRE_HI;
          end
        end
        B_FIRE_HI: begin
          fire  <= fire_step(fire, job.lead[15:8]);
          state <= B_FIRE_LO;
        end
        B_FIRE_LO: begin
          fire <= fire_step(fire, job.lead[7:0]);
          idx  <= 3'd0;
          if (ps_bad) begin
            err_status <= ST_PS;
            err_index  <= 3'd0;
            err_start  <= 12'd0;
            err_num    <= 3'd0;
            state      <= B_ERR;
          end else begin
            state <= B_CHECK;
          end
        end
        B_CHECK: begin
          priority if (order_bad || len_bad) begin
            err_status <= order_bad ? ST_ORDER : ST_LEN;
            err_index  <= idx;
            err_start  <= cur;
            err_num    <= n;
            state      <= B_ERR;
          end else if (is_last) begin
            idx <= 3'd0;
            if (fire != 16'd0) begin
              err_status <= ST_FIRE;
              err_index  <= 3'd0;
              err_start  <= 12'd0;
              err_num    <= n;
              state      <= B_ERR;
            end else begin
              state <= B_EMIT;
            end
          end else begin
            idx <= idx + 3'd1;
          end
        end
        B_ERR: begin
          if (load) begin
            out_rec.au_index  <= err_index;
            out_rec.au_offset <= err_start;
            out_rec.au_length <= 10'd0;
            out_rec.num_aus   <= err_num;
            out_rec.flags     <= job.flags;
            out_rec.status    <= err_status;
            out_rec.last      <= 1'b1;
            state             <= B_IDLE;
          end
        end
        B_EMIT: begin
          if (load) begin
            out_rec.au_index  <= idx;
            out_rec.au_offset <= cur;
            out_rec.au_length <= diff[9:0];
            out_rec.num_aus   <= n;
            out_rec.flags     <= job.flags;
            out_rec.status    <= ST_OK;
            out_rec.last      <= is_last;
            if (is_last) state <= B_IDLE;
            else         idx   <= idx + 3'd1;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sv/superframe_header_decode_check.sv
// A header completes on byte 10; the back sequencer then runs two Fire code steps and one
// check per access unit, then registers records at one a cycle while out_ready allows;
// an error gives a single record, and only then is a new job taken. One byte per cycle
// at the input unless a full queue stalls it; a two-word job queue lets the parser run ahead.
// Reset (rst, synchronous): clears parse state, queue, sequencer and super_frame_size.
// Top level of the super frame header decoder; depends on sfhd_pkg and its submodules.
`default_nettype none
module superframe_header_decode_check import sfhd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [12:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        frame_start,
  input  wire logic [7:0]  byte_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       au_index,
  output logic [11:0]      au_offset,
  output logic [9:0]       au_length,
  output logic [2:0]       num_aus,
  output logic             dac_rate_48k,
  output logic             sbr_used,
  output logic             stereo,
  output logic             ps_used,
  output logic [2:0]       status,
  output logic             last
);

  logic [12:0] super_frame_size;
  logic        q_full;
  logic        push;
  job_t        push_job;
  logic        pop;
  logic        q_valid;
  job_t        q_job;
  rec_t        rec;

  // hold the configured super frame size
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) super_frame_size <= 13'd0;
    else if (cfg_valid) super_frame_size <= cfg_data;
  end

  sfhd_front u_front (
    .clk, .rst, .in_valid, .in_ready, .frame_start, .byte_value,
    .q_full, .push, .push_job
  );

  sfhd_queue u_queue (
    .clk, .rst, .push, .push_job, .full(q_full),
    .pop, .pop_valid(q_valid), .pop_job(q_job)
  );

  sfhd_back u_back (
    .clk, .rst, .frame_size(super_frame_size), .q_valid, .q_job, .pop,
    .out_valid, .out_ready, .out_rec(rec)
  );

  // break out the record fields
  assign au_index     = rec.au_index;
  assign au_offset    = rec.au_offset;
  assign au_length    = rec.au_length;
  assign num_aus      = rec.num_aus;
  assign dac_rate_48k = rec.flags[3];
  assign sbr_used     = rec.flags[2];
  assign stereo       = rec.flags[1];
  assign ps_used      = rec.flags[0];
  assign status       = rec.status;
  assign last         = rec.last;

endmodule
`default_nettype wire

FILE: sv/sfhd_checker.sv
// Port-level checker for the super frame header decoder, bound to the top level.
// Depends on sfhd_pkg for status codes; the length limit is written as a literal.
`default_nettype none
module sfhd_checker import sfhd_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  au_index,
  input wire logic [11:0] au_offset,
  input wire logic [9:0]  au_length,
  input wire logic [2:0]  num_aus,
  input wire logic [2:0]  status,
  input wire logic        last
);

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(au_offset) && $stable(au_index)
      && $stable(status) && $stable(last))
    else $error("stalled output word changed");

  // an error word closes the frame
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> last)
    else $error("error word without last");

  // good words index within the unit count and respect the length limit
  a_ok_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_OK) |-> (au_index < num_aus) && (au_length <= 10'd962))
    else $error("good word out of range");

  // the first unit start matches the unit count
  a_first: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_OK) && (au_index == 3'd0) |->
      (num_aus == 3'd2 && au_offset == 12'd5) || (num_aus == 3'd3 && au_offset == 12'd6)
      || (num_aus == 3'd4 && au_offset == 12'd8) || (num_aus == 3'd6 && au_offset == 12'd11))
    else $error("first unit start does not match unit count");

  // the last good word is the final unit
  a_last_unit: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_OK) |-> (last == (au_index == num_aus - 3'd1)))
    else $error("last flag on wrong unit");

endmodule

bind superframe_header_decode_check sfhd_checker u_sfhd_checker (.*);
`default_nettype wire
